[src/itra_pkg.sv]
// Shared constants, types and helper functions for the integer to radix text converter.
`timescale 1ns / 1ps

package itra_pkg;

	// Width of the value field on the input port.
	localparam int IN_W        = 64;
	// Number of low bits of the value that are converted.
	localparam int VALUE_WIDTH = 64;
	// Upper bound on the text length in characters.
	localparam int MAX_TEXT    = 64;

	localparam int STORE_DEPTH = 64;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int DIGIT_W     = 6;
	localparam int RADIX_W     = 6;
	localparam int LEN_W       = 7;
	localparam int CFG_W       = 7;
	localparam int CFG_IDX_W   = 2;
	localparam int CHAR_W      = 8;
	localparam int STATUS_W    = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN    = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [RADIX_W-1:0] RADIX_RESET      = 6'd10;
	localparam logic [LEN_W-1:0]   BUFFER_LEN_RESET = 7'd10;
	localparam logic [LEN_W-1:0]   MIN_LEN_RESET    = 7'd0;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [LEN_W-1:0]   BUFFER_MIN = 7'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BUFFER  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RADIX   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_PADDING = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd4;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

	// Response of the shared divider.
	typedef struct packed {
		logic               done;
		logic [DIGIT_W-1:0] remainder;
	} div_resp_t;

	// Maps a digit value to its ASCII character: 0-9 then A-Z.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dw;
		dw = {2'b00, d};
		if (dw < 8'd10) begin
			return CHAR_ZERO + dw;
		end else if (dw < 8'd36) begin
			return CHAR_A + (dw - 8'd10);
		end else begin
			return CHAR_ZERO;
		end
	endfunction

endpackage

[src/itra_ram.sv]
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps

module itra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/itra_divider.sv]
// Shared restoring divider: one quotient bit per cycle, value divided by the radix.
`timescale 1ns / 1ps

module itra_divider (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [itra_pkg::VALUE_WIDTH-1:0]     dividend,
	input  logic [itra_pkg::RADIX_W-1:0]         divisor,
	output logic [itra_pkg::VALUE_WIDTH-1:0]     quotient,
	output itra_pkg::div_resp_t                  resp
);
	import itra_pkg::*;

	localparam int CNT_W = $clog2(VALUE_WIDTH);

	logic [VALUE_WIDTH-1:0] dq_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;

	logic [RADIX_W:0] trial;
	logic [RADIX_W:0] diff;
	logic             ge;

	// The dividend shifts out at the top while quotient bits shift in at the bottom.
	assign trial = {rem_q, dq_q[VALUE_WIDTH-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_W'(VALUE_WIDTH - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(VALUE_WIDTH - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= {dq_q[VALUE_WIDTH-2:0], ge};
			rem_q <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
		end
	end

	assign quotient       = dq_q;
	assign resp.done      = done_q;
	assign resp.remainder = rem_q;

endmodule

[src/int_to_radix_ascii.sv]
// Top level: signed integer to ASCII text in a configurable radix, one character per item.
`timescale 1ns / 1ps
// Each digit takes one pass through the shared divider (start, 64 bit steps, done), and
// all digits are produced before the first character is sent.
// Input is stalled from acceptance until the final character enters the output register.
// Reset: asynchronous and active low; radix 10, buffer length 10, minimum length 0.
// The digit store is not cleared; every conversion writes each entry it reads.

module int_to_radix_ascii (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_write,
	input  logic [itra_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [itra_pkg::CFG_W-1:0]           cfg_data,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [itra_pkg::IN_W-1:0]            value,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [itra_pkg::CHAR_W-1:0]          character,
	output logic                                 last,
	output logic [itra_pkg::STATUS_W-1:0]        status
);
	import itra_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV_START,
		S_DIV_WAIT,
		S_LEN_CHECK,
		S_EMIT_FETCH,
		S_EMIT_PUT,
		S_ERROR
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [RADIX_W-1:0] radix_q;
	logic [LEN_W-1:0]   buffer_length_q;
	logic [LEN_W-1:0]   min_length_q;

	// Per-item working registers.
	logic [VALUE_WIDTH-1:0] remaining_q;
	logic [LEN_W-1:0]       digit_count_q;
	logic [LEN_W-1:0]       room_q;
	logic                   neg_q;
	logic [STATUS_W-1:0]    err_q;
	logic                   sign_pend_q;
	logic [LEN_W-1:0]       pad_left_q;
	logic [LEN_W-1:0]       dig_left_q;
	logic [LEN_W-1:0]       chars_left_q;

	// Output register.
	logic                   out_valid_q;
	logic [CHAR_W-1:0]      character_q;
	logic                   last_q;
	logic [STATUS_W-1:0]    status_q;

	logic [VALUE_WIDTH-1:0] raw_c;
	logic                   neg_c;
	logic [VALUE_WIDTH-1:0] mag_c;
	logic [LEN_W-1:0]       buf_m1_c;
	logic [LEN_W-1:0]       room_c;
	logic [STATUS_W-1:0]    check_c;
	logic [LEN_W-1:0]       text_len_c;
	logic                   accept_in;
	logic                   out_free;
	logic                   load_out_c;
	logic [LEN_W-1:0]       dig_idx_c;

	logic                   div_start;
	logic [VALUE_WIDTH-1:0] div_quot;
	div_resp_t              div_resp;
	logic                   ram_we;
	logic [DIGIT_W-1:0]     ram_rdata;

	// Only the low VALUE_WIDTH bits are converted; the most negative value negates to
	// 2^(VALUE_WIDTH-1), which is still correct as an unsigned magnitude.
	assign raw_c = value[VALUE_WIDTH-1:0];
	assign neg_c = raw_c[VALUE_WIDTH-1];
	assign mag_c = neg_c ? (~raw_c + 1'b1) : raw_c;

	// Usable room is the buffer minus its terminator, capped at the text limit.
	assign buf_m1_c = buffer_length_q - 1'b1;
	assign room_c   = (buf_m1_c > LEN_W'(MAX_TEXT)) ? LEN_W'(MAX_TEXT) : buf_m1_c;

	// Settings checks, in priority order. They depend only on configuration, so they
	// are resolved in the cycle the item is accepted.
	always_comb begin
		if (buffer_length_q < BUFFER_MIN) begin
			check_c = ST_BUFFER;
		end else if (radix_q < RADIX_MIN || radix_q > RADIX_MAX) begin
			check_c = ST_RADIX;
		end else if (min_length_q > room_c) begin
			check_c = ST_PADDING;
		end else begin
			check_c = ST_OK;
		end
	end

	assign text_len_c = digit_count_q + {{(LEN_W-1){1'b0}}, neg_q};

	assign in_stall  = (state_q != S_IDLE);
	assign accept_in = in_valid && !in_stall;
	// The output register can take a new character when empty or being drained.
	assign out_free  = !out_valid_q || !out_stall;
	// A character or an error item enters the output register this cycle.
	assign load_out_c = out_free && (state_q inside {S_EMIT_PUT, S_ERROR});

	assign div_start = (state_q == S_DIV_START);
	assign ram_we    = (state_q == S_DIV_WAIT) && div_resp.done;

	// Digits sit least significant first, so the most significant unsent digit lives at
	// index dig_left - 1. The address is the dig_left register less one and the store's read port
	// is registered, so the read data is valid in the cycle after the pointer moves.
	assign dig_idx_c = dig_left_q - 1'b1;

	itra_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (remaining_q),
		.divisor  (radix_q),
		.quotient (div_quot),
		.resp     (div_resp)
	);

	itra_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (STORE_DEPTH)
	) u_digit_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (digit_count_q[STORE_AW-1:0]),
		.wdata (div_resp.remainder),
		.raddr (dig_idx_c[STORE_AW-1:0]),
		.rdata (ram_rdata)
	);

	// Configuration writes; an index beyond the register list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q         <= RADIX_RESET;
			buffer_length_q <= BUFFER_LEN_RESET;
			min_length_q    <= MIN_LEN_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_RADIX:      radix_q         <= cfg_data[RADIX_W-1:0];
				REG_BUFFER_LEN: buffer_length_q <= cfg_data[LEN_W-1:0];
				REG_MIN_LEN:    min_length_q    <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer: divide repeatedly until the quotient is zero, check the length, then send
	// sign, padding zeros and digits, one character per pass through the emit loop, or a NUL on error.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			remaining_q   <= '0;
			digit_count_q <= '0;
		end else begin
			if (load_out_c) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept_in) begin
						neg_q  <= neg_c;
						room_q <= room_c;
						err_q  <= check_c;
						if (check_c != ST_OK) begin
							state_q <= S_ERROR;
						end else begin
							remaining_q   <= mag_c;
							digit_count_q <= '0;
							state_q       <= S_DIV_START;
						end
					end
				end
				S_DIV_START: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_resp.done) begin
						remaining_q   <= div_quot;
						digit_count_q <= digit_count_q + 1'b1;
						state_q       <= (div_quot == '0) ? S_LEN_CHECK : S_DIV_START;
					end
				end
				S_LEN_CHECK: begin
					if (text_len_c > room_q) begin
						err_q   <= ST_TOO_LONG;
						state_q <= S_ERROR;
					end else begin
						sign_pend_q  <= neg_q;
						dig_left_q   <= digit_count_q;
						if (min_length_q > text_len_c) begin
							pad_left_q   <= min_length_q - text_len_c;
							chars_left_q <= min_length_q;
						end else begin
							pad_left_q   <= '0;
							chars_left_q <= text_len_c;
						end
						state_q <= S_EMIT_FETCH;
					end
				end
				S_EMIT_FETCH: begin
					state_q <= S_EMIT_PUT;
				end
				S_EMIT_PUT: begin
					if (out_free) begin
						status_q    <= ST_OK;
						last_q      <= (chars_left_q == LEN_W'(1));
						if (sign_pend_q) begin
							character_q <= CHAR_MINUS;
							sign_pend_q <= 1'b0;
						end else if (pad_left_q != '0) begin
							character_q <= CHAR_ZERO;
							pad_left_q  <= pad_left_q - 1'b1;
						end else begin
							character_q <= digit_char(ram_rdata);
							dig_left_q  <= dig_left_q - 1'b1;
						end
						chars_left_q <= chars_left_q - 1'b1;
						state_q      <= (chars_left_q == LEN_W'(1)) ? S_IDLE : S_EMIT_FETCH;
					end
				end
				S_ERROR: begin
					if (out_free) begin
						character_q <= CHAR_NUL;
						last_q      <= 1'b1;
						status_q    <= err_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign character = character_q;
	assign last      = last_q;
	assign status    = status_q;

`ifndef SYNTHESIS
	// An error result is always a single NUL character that closes the text.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last && character == CHAR_NUL)
		else $error("error result is not a lone terminating NUL");

	// The divider only reports completion while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_resp.done |-> state_q == S_DIV_WAIT)
		else $error("divider finished outside the divide phase");

	// A conversion never makes more digits than the store holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		digit_count_q <= LEN_W'(STORE_DEPTH))
		else $error("digit count exceeds the digit store");

	// Once an item is taken, the block is busy on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept_in |=> in_stall)
		else $error("input accepted without going busy");
`endif

endmodule
